// ===== design/analog_stick_radial_deadzone_defines.svh =====
// assertion macros for the analog stick conditioner
// expects clk and arst_n in the scope of each use
`ifndef ANALOG_STICK_RADIAL_DEADZONE_DEFINES_SVH
`define ANALOG_STICK_RADIAL_DEADZONE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASRD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("asrd: invariant violated");
`define ASRD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("asrd: implication violated");
`define ASRD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("asrd: next-cycle check violated");
`else
`define ASRD_ASSERT_ALWAYS(label, cond)
`define ASRD_ASSERT_IMP(label, ante, cons)
`define ASRD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== design/asrd_pkg.sv =====
// shared constants, register codes and curve table functions for the stick conditioner
// no dependencies
package asrd_pkg;

	localparam int OVERSAMPLE_DEF  = 8;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int CURVE_DEPTH_DEF = 1024;

	// curved magnitude in q16, at most about 2^0.65
	localparam int VAL_W   = 17;
	localparam int MUL_W   = 18;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int DIV_N_W = 36;
	localparam int DIV_D_W = 18;
	localparam int LEN_W   = 18;
	localparam int SQ_W    = 36;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int DZ_W    = 16;
	localparam int OUT_W   = 16;
	localparam int DEST_W  = 2;
	localparam int SCALE_W = 17;
	localparam int Q16_ONE = 65536;

	typedef enum logic [2:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_INVERT     = 3'd2,
		REG_INNER_DZ   = 3'd3,
		REG_OUTER_DZ   = 3'd4,
		REG_TARGET     = 3'd5
	} reg_idx_t;

	localparam logic [DEST_W-1:0] DEST_NONE  = 2'd0;
	localparam logic [DEST_W-1:0] DEST_LEFT  = 2'd1;
	localparam logic [DEST_W-1:0] DEST_RIGHT = 2'd2;

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = 64'd0;
		b = 64'h4000_0000_0000_0000;
		for (int k = 0; k < 32; k++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// q16 log2, fraction by repeated squaring
	function automatic longint log2_q16(input logic [31:0] n);
		logic [31:0] e;
		logic [31:0] frac;
		logic [63:0] y;
		e = 32'd0;
		frac = 32'd0;
		for (int k = 0; k < 30; k++) begin
			if ((n >> (e + 32'd1)) != 32'd0) e = e + 32'd1;
		end
		y = {32'd0, n} << (32'd30 - e);
		for (int bt = 15; bt >= 0; bt--) begin
			y = (y * y) >> 30;
			if (y >= 64'h8000_0000) begin
				y = y >> 1;
				frac = frac | (32'd1 << bt);
			end
		end
		return $signed({32'd0, e}) * 64'sd65536 + $signed({32'd0, frac});
	endfunction

	function automatic logic [31:0] exp2_q16(input longint g);
		longint h;
		logic [63:0] r;
		logic [63:0] root [17];
		logic [31:0] q;
		logic [31:0] f;
		logic [31:0] sh;
		logic [63:0] rnd;
		root[0] = 64'd1 << 31;
		root[1] = isqrt64(64'd2 << 60);
		for (int k = 1; k < 16; k++) root[k+1] = isqrt64(root[k] << 30);
		h = g + 64'sd16 * 64'sd65536;
		if (h < 0) return 32'd0;
		q = 32'(h >>> 16);
		f = 32'(h & 64'sd65535);
		if (q > 32'd29) q = 32'd29;
		r = 64'd1 << 30;
		for (int k = 1; k <= 16; k++) begin
			if (f[16-k]) r = (r * root[k]) >> 30;
		end
		sh = 32'd30 - q;
		rnd = (r + (64'd1 << (sh - 32'd1))) >> sh;
		return rnd[31:0];
	endfunction

	// entry i of the power curve: (2i/(depth-1))^0.65 in q16
	function automatic logic [31:0] curve_entry(input int i, input int depth);
		longint lref;
		longint l;
		longint g;
		if (i == 0) return 32'd0;
		lref = log2_q16(32'(depth - 1));
		l = 64'sd65536 + log2_q16(32'(i)) - lref;
		g = (l * 64'sd13) / 64'sd20;
		return exp2_q16(g);
	endfunction

endpackage

// ===== design/asrd_if.sv =====
// valid/ready channels for raw sample pairs and conditioned stick results
// depends on asrd_pkg
interface asrd_sample_if import asrd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_x;
	logic [SAMPLE_BITS-1:0] sample_y;
	modport source (output valid, sample_x, sample_y, input ready);
	modport sink (input valid, sample_x, sample_y, output ready);
endinterface

interface asrd_stick_if import asrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OUT_W-1:0]  stick_x;
	logic [OUT_W-1:0]  stick_y;
	logic [DEST_W-1:0] destination;
	modport source (output valid, stick_x, stick_y, destination, input ready);
	modport sink (input valid, stick_x, stick_y, destination, output ready);
endinterface

// ===== design/analog_stick_radial_deadzone.sv =====
// radial deadzone conditioner for one two-axis analog stick, top level
// depends on asrd_pkg, asrd_if and analog_stick_radial_deadzone_defines.svh
//
// Raw sample pairs are taken one per cycle and summed. Every OVERSAMPLE-th
// pair starts a conditioning run, and the sample port holds ready low until
// the run has finished. A small sequencer drives the run over one shared
// 18x18 multiplier, one bit-serial 36-bit divider and a one-bit-per-step
// square root. The average is a reciprocal multiplication by a constant.
// The division by full scale is a shift, add and compare-subtract. The
// divider only serves the deadzone scale and the two rescaled axes. The
// other steps are averaging, curve lookup, squaring, the root and output
// mapping. Inside the deadzone both divisions are skipped, and a reversed
// deadzone skips the scale division. The result then waits in an output
// register while the next group accumulates. The curve table is built
// from constants at elaboration and read through a registered port.
// Registers sit on an APB port at byte offsets 0,4..20.
`include "analog_stick_radial_deadzone_defines.svh"

module analog_stick_radial_deadzone import asrd_pkg::*; #(
	parameter int OVERSAMPLE        = OVERSAMPLE_DEF,
	parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
	parameter int CURVE_TABLE_DEPTH = CURVE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	asrd_sample_if.sink       sample,
	asrd_stick_if.source      stick,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int B        = SAMPLE_BITS;
	localparam int SUM_W    = SAMPLE_BITS + $clog2(OVERSAMPLE + 1);
	localparam int CNT_W    = $clog2(OVERSAMPLE + 1);
	localparam int IDX_W    = $clog2(CURVE_TABLE_DEPTH);
	localparam int ADC_FULL = (1 << SAMPLE_BITS) - 1;
	localparam int DIV_C_W  = $clog2(DIV_N_W + 1);
	// reciprocal of the group size, exact for every sum that fits SUM_W bits
	localparam int AVG_S    = SUM_W + $clog2(OVERSAMPLE);
	localparam longint unsigned AVG_M = ((64'd1 << AVG_S) + OVERSAMPLE - 1) / OVERSAMPLE;
	localparam int AVG_P_W  = SUM_W + AVG_S + 1;

	typedef enum logic [19:0] {
		ST_IDLE   = 20'd1 << 0,
		ST_AVG    = 20'd1 << 1,
		ST_CTR    = 20'd1 << 2,
		ST_IDX    = 20'd1 << 3,
		ST_LO     = 20'd1 << 4,
		ST_HI     = 20'd1 << 5,
		ST_FRAC   = 20'd1 << 6,
		ST_FRAC_D = 20'd1 << 7,
		ST_SQX    = 20'd1 << 8,
		ST_SQY    = 20'd1 << 9,
		ST_SQS    = 20'd1 << 10,
		ST_SQRT   = 20'd1 << 11,
		ST_ZONE   = 20'd1 << 12,
		ST_SCL_W  = 20'd1 << 13,
		ST_SCX    = 20'd1 << 14,
		ST_RX     = 20'd1 << 15,
		ST_RX_W   = 20'd1 << 16,
		ST_OUTX   = 20'd1 << 17,
		ST_OUTY   = 20'd1 << 18,
		ST_DONE   = 20'd1 << 19
	} state_t;

	// curve table, constant
	logic [VAL_W-1:0] curve_rom [CURVE_TABLE_DEPTH];
	for (genvar gi = 0; gi < CURVE_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [31:0] ENTRY = curve_entry(gi, CURVE_TABLE_DEPTH);
		assign curve_rom[gi] = ENTRY[VAL_W-1:0];
	end

	// configuration
	logic [B-1:0]      center_x_q, center_y_q;
	logic [1:0]        invert_q;
	logic [DZ_W-1:0]   inner_q, outer_q;
	logic [DEST_W-1:0] target_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	// sequencer and datapath
	state_t            state_q, state_d;
	logic              axis_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_x_q, sum_y_q;
	logic [B-1:0]      raw_q;
	logic [1:0]        neg_q;
	logic [VAL_W-1:0]  mag_q [2];
	logic [IDX_W-1:0]  idx_q;
	logic [B-1:0]      fr_q;
	logic [VAL_W-1:0]  lo_q, rom_q;
	logic [IDX_W-1:0]  rom_addr;
	logic [SQ_W-2:0]   acc_q;
	logic [SQ_W-1:0]   sq_v_q, sq_r_q, sq_b_q;
	logic [SCALE_W-1:0] scale_q;
	logic [SCALE_W-1:0] res_q [2];
	logic [OUT_W-1:0]  outx_q;

	// averaging by reciprocal multiplication
	logic [SUM_W-1:0]   avg_sum;
	logic [AVG_P_W-1:0] avg_prod;
	logic [B-1:0]       avg_val;

	// division of the product by full scale
	logic [PROD_W-1:0] fd_q, fd_r, fd_t;

	// shared multiplier
	logic              mul_en;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] mul_p_q;

	// shared divider
	logic               div_start;
	logic [DIV_N_W-1:0] div_num;
	logic [DIV_D_W-1:0] div_den;
	logic [DIV_N_W-1:0] div_quo_q;
	logic [DIV_D_W-1:0] div_rem_q, div_den_q;
	logic [DIV_C_W-1:0] div_cnt_q;
	logic [DIV_D_W:0]   div_trial;
	logic               div_ge;
	logic               div_done;

	// output register
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_x_q, out_y_q;
	logic [DEST_W-1:0] out_dest_q;
	logic              out_load;
	logic              in_fire;

	// centring
	logic signed [B+1:0] ctr_d;
	logic [B-1:0]        ctr_ad;
	logic                ctr_neg;

	// sqrt step
	logic [SQ_W-1:0]   sq_t;
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  len_sub;
	logic [MUL_W-1:0]  off_x, off_y;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= B'(1) << (B - 1);
			center_y_q <= B'(1) << (B - 1);
			invert_q   <= 2'd0;
			inner_q    <= '0;
			outer_q    <= '1;
			target_q   <= DEST_LEFT;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_CENTER_X: center_x_q <= pwdata[B-1:0];
				REG_CENTER_Y: center_y_q <= pwdata[B-1:0];
				REG_INVERT:   invert_q   <= pwdata[1:0];
				REG_INNER_DZ: inner_q    <= pwdata[DZ_W-1:0];
				REG_OUTER_DZ: outer_q    <= pwdata[DZ_W-1:0];
				REG_TARGET:   target_q   <= pwdata[DEST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CENTER_X: prdata = DATA_W'(center_x_q);
			REG_CENTER_Y: prdata = DATA_W'(center_y_q);
			REG_INVERT:   prdata = DATA_W'(invert_q);
			REG_INNER_DZ: prdata = DATA_W'(inner_q);
			REG_OUTER_DZ: prdata = DATA_W'(outer_q);
			REG_TARGET:   prdata = DATA_W'(target_q);
			default:      prdata = '0;
		endcase
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign in_fire      = sample.valid && sample.ready;
	assign out_load     = (state_q == ST_DONE) && (!out_valid_q || stick.ready);

	assign div_trial = {div_rem_q, div_quo_q[DIV_N_W-1]};
	assign div_ge    = div_trial >= {1'b0, div_den_q};
	assign div_done  = (div_cnt_q == '0);

	assign avg_sum  = axis_q ? sum_y_q : sum_x_q;
	assign avg_prod = AVG_P_W'(avg_sum) * AVG_P_W'(AVG_M);
	assign avg_val  = avg_prod[AVG_S +: B];

	// full scale is 2^B-1: fold the high part onto the low part repeatedly, then one correction
	always_comb begin
		fd_q = mul_p_q >> B;
		fd_r = PROD_W'(mul_p_q[B-1:0]) + fd_q;
		fd_t = '0;
		for (int k = 0; k < 3; k++) begin
			fd_t = fd_r >> B;
			fd_q = fd_q + fd_t;
			fd_r = PROD_W'(fd_r[B-1:0]) + fd_t;
		end
		if (fd_r >= PROD_W'(ADC_FULL)) begin
			fd_q = fd_q + 1'b1;
			fd_r = fd_r - PROD_W'(ADC_FULL);
		end
	end

	assign len     = sq_r_q[LEN_W-1:0];
	assign len_sub = len - LEN_W'(inner_q);
	assign sq_t    = sq_r_q + sq_b_q;
	assign off_x   = neg_q[0] ? MUL_W'(Q16_ONE) - MUL_W'(res_q[0])
	                          : MUL_W'(Q16_ONE) + MUL_W'(res_q[0]);
	assign off_y   = neg_q[1] ? MUL_W'(Q16_ONE) - MUL_W'(res_q[1])
	                          : MUL_W'(Q16_ONE) + MUL_W'(res_q[1]);

	always_comb begin
		ctr_d = $signed({2'b00, raw_q})
		      - $signed({2'b00, (axis_q ? center_y_q : center_x_q)});
		if (invert_q[axis_q]) ctr_d = -ctr_d;
		ctr_neg = ctr_d[B+1];
		ctr_ad  = ctr_neg ? B'(-ctr_d) : ctr_d[B-1:0];
	end

	// sequencer: next state, multiplier and divider operand selection, curve table address
	always_comb begin
		state_d   = state_q;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		rom_addr  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && cnt_q == CNT_W'(OVERSAMPLE - 1)) state_d = ST_AVG;
			end
			ST_AVG: state_d = ST_CTR;
			ST_CTR: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(ctr_ad);
				mul_b   = MUL_W'(CURVE_TABLE_DEPTH - 1);
				state_d = ST_IDX;
			end
			ST_IDX: state_d = ST_LO;
			ST_LO: state_d = ST_HI;
			ST_HI: begin
				rom_addr = IDX_W'(idx_q + 1'b1);
				if (idx_q == IDX_W'(CURVE_TABLE_DEPTH - 1)) begin
					state_d = axis_q ? ST_SQX : ST_AVG;
				end else begin
					state_d = ST_FRAC;
				end
			end
			ST_FRAC: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(rom_q - lo_q);
				mul_b   = MUL_W'(fr_q);
				state_d = ST_FRAC_D;
			end
			ST_FRAC_D: state_d = axis_q ? ST_SQX : ST_AVG;
			ST_SQX: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(mag_q[0]);
				mul_b   = MUL_W'(mag_q[0]);
				state_d = ST_SQY;
			end
			ST_SQY: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(mag_q[1]);
				mul_b   = MUL_W'(mag_q[1]);
				state_d = ST_SQS;
			end
			ST_SQS: state_d = ST_SQRT;
			ST_SQRT: if (sq_b_q[0]) state_d = ST_ZONE;
			ST_ZONE: begin
				if (len >= LEN_W'(inner_q) && len != '0) begin
					if (outer_q <= inner_q) begin
						state_d = ST_SCX;
					end else begin
						div_start = 1'b1;
						div_num   = DIV_N_W'({len_sub, 16'd0});
						div_den   = DIV_D_W'(outer_q - inner_q);
						state_d   = ST_SCL_W;
					end
				end else begin
					state_d = ST_OUTX;
				end
			end
			ST_SCL_W: if (div_done) state_d = ST_SCX;
			ST_SCX: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(mag_q[axis_q]);
				mul_b   = MUL_W'(scale_q);
				state_d = ST_RX;
			end
			ST_RX: begin
				div_start = 1'b1;
				div_num   = DIV_N_W'(mul_p_q);
				div_den   = DIV_D_W'(len);
				state_d   = ST_RX_W;
			end
			ST_RX_W: if (div_done) state_d = axis_q ? ST_OUTX : ST_SCX;
			ST_OUTX: begin
				mul_en  = 1'b1;
				mul_a   = off_x;
				mul_b   = MUL_W'(16'hFFFF);
				state_d = ST_OUTY;
			end
			ST_OUTY: begin
				mul_en  = 1'b1;
				mul_a   = off_y;
				mul_b   = MUL_W'(16'hFFFF);
				state_d = ST_DONE;
			end
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				sum_x_q <= sum_x_q + SUM_W'(sample.sample_x);
				sum_y_q <= sum_y_q + SUM_W'(sample.sample_y);
				cnt_q   <= (cnt_q == CNT_W'(OVERSAMPLE - 1)) ? '0 : CNT_W'(cnt_q + 1'b1);
			end
			if (state_q == ST_SQX) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
			end
			// axis toggles when one axis finishes a curve or a rescale
			if ((state_q == ST_HI && idx_q == IDX_W'(CURVE_TABLE_DEPTH - 1))
			    || (state_q == ST_FRAC_D)
			    || (state_q == ST_RX_W && div_done)) begin
				axis_q <= !axis_q;
			end
			if (div_start) begin
				div_cnt_q <= DIV_C_W'(DIV_N_W);
			end else if (!div_done) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (stick.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rom_q <= curve_rom[rom_addr];
		if (mul_en) mul_p_q <= mul_a * mul_b;
		if (div_start) begin
			div_quo_q <= div_num;
			div_rem_q <= '0;
			div_den_q <= div_den;
		end else if (!div_done) begin
			div_quo_q <= {div_quo_q[DIV_N_W-2:0], div_ge};
			div_rem_q <= div_ge ? DIV_D_W'(div_trial - {1'b0, div_den_q})
			                    : div_trial[DIV_D_W-1:0];
		end
		case (state_q)
			ST_AVG:   raw_q <= avg_val;
			ST_CTR:   neg_q[axis_q] <= ctr_neg;
			ST_IDX: begin
				idx_q <= fd_q[IDX_W-1:0];
				fr_q  <= fd_r[B-1:0];
			end
			ST_HI: begin
				lo_q <= rom_q;
				if (idx_q == IDX_W'(CURVE_TABLE_DEPTH - 1)) mag_q[axis_q] <= rom_q;
			end
			ST_FRAC_D: mag_q[axis_q] <= lo_q + fd_q[VAL_W-1:0];
			ST_SQY: acc_q <= mul_p_q[SQ_W-2:0];
			ST_SQS: begin
				sq_v_q <= SQ_W'(acc_q) + SQ_W'(mul_p_q);
				sq_r_q <= '0;
				sq_b_q <= SQ_W'(1) << (SQ_W - 2);
			end
			ST_SQRT: begin
				if (sq_v_q >= sq_t) begin
					sq_v_q <= sq_v_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q <= sq_b_q >> 2;
			end
			ST_ZONE: begin
				scale_q  <= SCALE_W'(Q16_ONE);
				res_q[0] <= '0;
				res_q[1] <= '0;
			end
			ST_SCL_W: begin
				if (div_done) begin
					scale_q <= (div_quo_q > DIV_N_W'(Q16_ONE)) ? SCALE_W'(Q16_ONE)
					                                          : div_quo_q[SCALE_W-1:0];
				end
			end
			ST_RX_W: if (div_done) res_q[axis_q] <= div_quo_q[SCALE_W-1:0];
			ST_OUTY: outx_q <= mul_p_q[OUT_W+16:17];
			default: ;
		endcase
		if (out_load) begin
			out_x_q    <= outx_q;
			out_y_q    <= mul_p_q[OUT_W+16:17];
			out_dest_q <= (target_q == DEST_LEFT || target_q == DEST_RIGHT) ? target_q
			                                                                : DEST_NONE;
		end
	end

	assign stick.valid       = out_valid_q;
	assign stick.stick_x     = out_x_q;
	assign stick.stick_y     = out_y_q;
	assign stick.destination = out_dest_q;

	`ASRD_ASSERT_ALWAYS(a_cnt_range, cnt_q < CNT_W'(OVERSAMPLE))
	`ASRD_ASSERT_IMP(a_div_owner, div_cnt_q != '0, state_q == ST_SCL_W || state_q == ST_RX_W)
	`ASRD_ASSERT_NXT(a_group_start, in_fire && cnt_q == CNT_W'(OVERSAMPLE - 1), state_q == ST_AVG && cnt_q == '0)
	`ASRD_ASSERT_IMP(a_sqrt_bit, state_q == ST_SQRT, $onehot(sq_b_q))

endmodule
